// ----- sv/ils_pkg.sv -----
package ils_pkg;

    // request codes
    typedef enum logic [2:0] {
        KIND_APPEND = 3'd0,
        KIND_GET    = 3'd1,
        KIND_SET    = 3'd2,
        KIND_INSERT = 3'd3,
        KIND_REMOVE = 3'd4,
        KIND_POP    = 3'd5,
        KIND_FIND   = 3'd6,
        KIND_CLEAR  = 3'd7
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_ZERO      = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // what every cell of the row does in a cycle
    typedef enum logic [2:0] {
        CELL_HOLD   = 3'd0,
        CELL_WRITE  = 3'd1,
        CELL_INSERT = 3'd2,
        CELL_REMOVE = 3'd3,
        CELL_MATCH  = 3'd4,
        CELL_SHIFT  = 3'd5
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     key_zero;
    } cell_ctl_t;

endpackage

// ----- sv/ils_if.sv -----
interface ils_req_if #(
    parameter int POS_W  = 7,
    parameter int ELEM_W = 32
);
    logic              valid;
    logic              ready;
    logic [2:0]        kind;
    logic [POS_W-1:0]  position;
    logic [ELEM_W-1:0] element;

    modport source (output valid, kind, position, element, input ready);
    modport sink   (input valid, kind, position, element, output ready);
endinterface

interface ils_rsp_if #(
    parameter int POS_W  = 7,
    parameter int IDX_W  = 6,
    parameter int ELEM_W = 32
);
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [ELEM_W-1:0] read_element;
    logic              found;
    logic [IDX_W-1:0]  found_position;
    logic [POS_W-1:0]  length;
    logic              empty_res;

    modport source (output valid, status, read_element, found, found_position, length,
                    empty_res, input ready);
    modport sink   (input valid, status, read_element, found, found_position, length,
                    empty_res, output ready);
endinterface

// ----- sv/indexed_list_store_core.sv -----
// channel | modport | payload
// --------+---------+-------------------------------------------------------------
// req     | sink    | kind, position, element
// rsp     | source  | status, read_element, found, found_position, length, empty_res
//
// every request but a find is done at once: the cells of the row shift or write in
// parallel, and the answer word goes to the output register, or to the skid register
// while rsp holds the output; so is a find with a zero key or on an empty list. any
// other find first compares in every cell, then the match flags shift one cell at a time towards cell 0.
// reset empties the list; no clearing pass is needed.
// rsp has an output and a skid register; a second waiting word holds req off.
module indexed_list_store_core #(
    parameter int CAPACITY      = 64,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    ils_req_if.sink       req,
    ils_rsp_if.source     rsp
);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    typedef struct packed {
        logic [1:0]               status;
        logic [ELEMENT_WIDTH-1:0] read_element;
        logic                     found;
        logic [IDX_W-1:0]         found_position;
        logic [CNT_W-1:0]         length;
        logic                     empty_res;
    } res_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    res_t             out_reg, out_next;
    res_t             skid_reg, skid_next;

    ils_pkg::cell_ctl_t       ctl;
    logic [CNT_W-1:0]         addr;
    logic                     emit;
    res_t                     emit_res;
    logic                     acc;
    logic                     take;
    logic                     elem_zero;
    logic                     full;
    logic                     scan_last;
    ils_pkg::kind_t           kind;
    logic [ELEMENT_WIDTH-1:0] rd_or;

    logic [ELEMENT_WIDTH-1:0] entry_w [CAPACITY];
    logic [ELEMENT_WIDTH-1:0] rd_w    [CAPACITY];
    logic                     match_w [CAPACITY];

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [ELEMENT_WIDTH-1:0] prev_e;
            logic [ELEMENT_WIDTH-1:0] next_e;
            logic                     next_m;
            if (gi == 0)
            begin : g_first
                assign prev_e = '0;
            end
            else
            begin : g_mid
                assign prev_e = entry_w[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_last
                assign next_e = '0;
                assign next_m = 1'b0;
            end
            else
            begin : g_inner
                assign next_e = entry_w[gi+1];
                assign next_m = match_w[gi+1];
            end

            ils_cell #(
                .ELEM_W (ELEMENT_WIDTH),
                .ADDR_W (CNT_W),
                .IDX    (gi)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .addr       (addr),
                .count      (count_reg),
                .elem       (req.element),
                .prev_entry (prev_e),
                .next_entry (next_e),
                .next_match (next_m),
                .entry      (entry_w[gi]),
                .match      (match_w[gi]),
                .rd_data    (rd_w[gi])
            );
        end
    endgenerate

    // at most one cell is addressed, so an or gives its word
    always_comb
    begin
        rd_or = '0;
        for (int i = 0; i < CAPACITY; i++)
            rd_or = rd_or | rd_w[i];
    end

    assign kind      = ils_pkg::kind_t'(req.kind);
    assign acc       = req.valid && req.ready;
    assign take      = out_valid_reg && rsp.ready;
    assign elem_zero = (req.element == '0);
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign scan_last = ((CNT_W'(scan_cnt_reg) + CNT_W'(1)) >= count_reg);
    assign req.ready = (state_reg == S_IDLE) && !skid_valid_reg;

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        scan_cnt_next = scan_cnt_reg;
        ctl.op        = ils_pkg::CELL_HOLD;
        ctl.key_zero  = elem_zero;
        addr          = req.position;
        emit          = 1'b0;
        emit_res      = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    emit            = 1'b1;
                    emit_res.status = ils_pkg::ST_OK;
                    unique case (kind)
                        ils_pkg::KIND_APPEND:
                        begin
                            addr = count_reg;
                            if (elem_zero)
                                emit_res.status = ils_pkg::ST_ZERO;
                            else if (full)
                                emit_res.status = ils_pkg::ST_FULL;
                            else
                            begin
                                ctl.op     = ils_pkg::CELL_WRITE;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        ils_pkg::KIND_GET:
                        begin
                            if (req.position >= count_reg)
                                emit_res.status = ils_pkg::ST_BAD_INDEX;
                            else
                                emit_res.read_element = rd_or;
                        end
                        ils_pkg::KIND_SET:
                        begin
                            if (req.position > count_reg)
                                emit_res.status = ils_pkg::ST_BAD_INDEX;
                            else if (elem_zero)
                                emit_res.status = ils_pkg::ST_ZERO;
                            else if (req.position == count_reg)
                            begin
                                // set at the end appends
                                if (full)
                                    emit_res.status = ils_pkg::ST_FULL;
                                else
                                begin
                                    ctl.op     = ils_pkg::CELL_WRITE;
                                    count_next = count_reg + CNT_W'(1);
                                end
                            end
                            else
                                ctl.op = ils_pkg::CELL_WRITE;
                        end
                        ils_pkg::KIND_INSERT:
                        begin
                            if (req.position > count_reg)
                                emit_res.status = ils_pkg::ST_BAD_INDEX;
                            else if (elem_zero)
                                emit_res.status = ils_pkg::ST_ZERO;
                            else if (full)
                                emit_res.status = ils_pkg::ST_FULL;
                            else
                            begin
                                ctl.op     = ils_pkg::CELL_INSERT;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        ils_pkg::KIND_REMOVE,
                        ils_pkg::KIND_POP:
                        begin
                            if (req.position >= count_reg)
                                emit_res.status = ils_pkg::ST_BAD_INDEX;
                            else
                            begin
                                if (kind == ils_pkg::KIND_POP)
                                    emit_res.read_element = rd_or;
                                ctl.op     = ils_pkg::CELL_REMOVE;
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        ils_pkg::KIND_FIND:
                        begin
                            if (elem_zero)
                                emit_res.status = ils_pkg::ST_ZERO;
                            else if (count_reg != '0)
                            begin
                                emit          = 1'b0;
                                ctl.op        = ils_pkg::CELL_MATCH;
                                scan_cnt_next = '0;
                                state_next    = S_SCAN;
                            end
                        end
                        ils_pkg::KIND_CLEAR:
                            count_next = '0;
                        default:
                            count_next = count_reg;
                    endcase
                    emit_res.length    = count_next;
                    emit_res.empty_res = (count_next == '0);
                end
            end
            S_SCAN:
            begin
                if (match_w[0] || scan_last)
                begin
                    if (!skid_valid_reg)
                    begin
                        emit                    = 1'b1;
                        emit_res.status         = ils_pkg::ST_OK;
                        emit_res.found          = match_w[0];
                        emit_res.found_position = match_w[0] ? scan_cnt_reg : '0;
                        emit_res.length         = count_reg;
                        emit_res.empty_res      = (count_reg == '0);
                        state_next              = S_IDLE;
                    end
                end
                else
                begin
                    // move every flag one cell down towards the head
                    ctl.op        = ils_pkg::CELL_SHIFT;
                    scan_cnt_next = scan_cnt_reg + IDX_W'(1);
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // output register with a skid word behind it
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (take)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                skid_valid_next = emit;
                skid_next       = emit_res;
            end
            else
            begin
                out_valid_next = emit;
                out_next       = emit_res;
            end
        end
        else if (!out_valid_reg)
        begin
            out_valid_next = emit;
            out_next       = emit_res;
        end
        else if (emit)
        begin
            skid_valid_next = 1'b1;
            skid_next       = emit_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            scan_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            scan_cnt_reg   <= scan_cnt_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_reg.status;
    assign rsp.read_element   = out_reg.read_element;
    assign rsp.found          = out_reg.found;
    assign rsp.found_position = out_reg.found_position;
    assign rsp.length         = out_reg.length;
    assign rsp.empty_res      = out_reg.empty_res;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held with an empty output register");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> CNT_W'(scan_cnt_reg) < count_reg)
        else $error("find scan ran past the list");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        acc && kind == ils_pkg::KIND_CLEAR |=> count_reg == '0)
        else $error("clear left entries behind");

    a_scan_no_count_change: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |=> $stable(count_reg))
        else $error("length changed during a find");

endmodule

// ----- sv/ils_cell.sv -----
module ils_cell #(
    parameter int ELEM_W = 32,
    parameter int ADDR_W = 7,
    parameter int IDX    = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ils_pkg::cell_ctl_t ctl,
    input  logic [ADDR_W-1:0] addr,
    input  logic [ADDR_W-1:0] count,
    input  logic [ELEM_W-1:0] elem,
    input  logic [ELEM_W-1:0] prev_entry,
    input  logic [ELEM_W-1:0] next_entry,
    input  logic              next_match,
    output logic [ELEM_W-1:0] entry,
    output logic              match,
    output logic [ELEM_W-1:0] rd_data
);
    localparam logic [ADDR_W-1:0] MY_IDX = ADDR_W'(IDX);

    logic [ELEM_W-1:0] entry_reg;
    logic [ELEM_W-1:0] entry_next;
    logic              match_reg;
    logic              match_next;

    always_comb
    begin
        entry_next = entry_reg;
        match_next = match_reg;
        case (ctl.op)
            ils_pkg::CELL_WRITE:
            begin
                if (MY_IDX == addr)
                    entry_next = elem;
            end
            ils_pkg::CELL_INSERT:
            begin
                if (MY_IDX == addr)
                    entry_next = elem;
                else if (MY_IDX > addr)
                    entry_next = prev_entry;
            end
            ils_pkg::CELL_REMOVE:
            begin
                if (MY_IDX >= addr)
                    entry_next = next_entry;
            end
            ils_pkg::CELL_MATCH:
                match_next = !ctl.key_zero && (MY_IDX < count) && (entry_reg == elem);
            ils_pkg::CELL_SHIFT:
                match_next = next_match;
            default:
            begin
                entry_next = entry_reg;
                match_next = match_reg;
            end
        endcase
    end

    // element words have no reset, they are only read once written
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            match_reg <= 1'b0;
        else
            match_reg <= match_next;
    end

    assign entry   = entry_reg;
    assign match   = match_reg;
    assign rd_data = (MY_IDX == addr) ? entry_reg : '0;

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps

module tb;

    localparam int CAPACITY  = 64;
    localparam int QUIET_MAX = 4000;

    typedef struct packed {
        ils_pkg::kind_t kind;
        logic [6:0]     position;
        logic [31:0]    element;
    } request_t;

    typedef struct packed {
        ils_pkg::status_t status;
        logic [31:0]      read_element;
        logic             found;
        logic [5:0]       found_position;
        logic [6:0]       length;
        logic             empty_res;
    } answer_t;

    typedef struct {
        logic [31:0] cells [CAPACITY];
        int unsigned count;
    } list_t;

    logic clk;
    logic rst_n;

    ils_req_if req_ch ();
    ils_rsp_if rsp_ch ();

    indexed_list_store_core #(
        .CAPACITY      (CAPACITY),
        .ELEMENT_WIDTH (32)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    request_t    pending_requests [$];
    answer_t     awaited_answers [$];
    list_t       stored_list;     // list contents as the block should hold them
    list_t       planned_list;    // list as the stimulus generator expects it to be
    request_t    next_request;
    answer_t     oldest;
    bit          steady;
    bit          growing;
    int          errors;
    int unsigned quiet_cycles;

    always #4 clk = ~clk;

    // one list operation, applied to the given copy of the list
    function automatic answer_t apply_request(ref list_t lst, input request_t w);
        answer_t     a;
        int unsigned p;
        int unsigned i;
        a = '0;
        a.status = ils_pkg::ST_OK;
        p = w.position;
        case (w.kind)
            ils_pkg::KIND_APPEND:
                if (w.element == 0)
                    a.status = ils_pkg::ST_ZERO;
                else if (lst.count >= CAPACITY)
                    a.status = ils_pkg::ST_FULL;
                else
                begin
                    lst.cells[lst.count] = w.element;
                    lst.count++;
                end
            ils_pkg::KIND_GET:
                if (p >= lst.count)
                    a.status = ils_pkg::ST_BAD_INDEX;
                else
                    a.read_element = lst.cells[p];
            ils_pkg::KIND_SET:
                if (p > lst.count)
                    a.status = ils_pkg::ST_BAD_INDEX;
                else if (w.element == 0)
                    a.status = ils_pkg::ST_ZERO;
                else if (p == lst.count)
                begin
                    if (lst.count >= CAPACITY)
                        a.status = ils_pkg::ST_FULL;
                    else
                    begin
                        lst.cells[lst.count] = w.element;
                        lst.count++;
                    end
                end
                else
                    lst.cells[p] = w.element;
            ils_pkg::KIND_INSERT:
                if (p > lst.count)
                    a.status = ils_pkg::ST_BAD_INDEX;
                else if (w.element == 0)
                    a.status = ils_pkg::ST_ZERO;
                else if (lst.count >= CAPACITY)
                    a.status = ils_pkg::ST_FULL;
                else
                begin
                    for (i = lst.count; i > p; i--)
                        lst.cells[i] = lst.cells[i - 1];
                    lst.cells[p] = w.element;
                    lst.count++;
                end
            ils_pkg::KIND_REMOVE, ils_pkg::KIND_POP:
                if (p >= lst.count)
                    a.status = ils_pkg::ST_BAD_INDEX;
                else
                begin
                    if (w.kind == ils_pkg::KIND_POP)
                        a.read_element = lst.cells[p];
                    for (i = p; i + 1 < lst.count; i++)
                        lst.cells[i] = lst.cells[i + 1];
                    lst.count--;
                end
            ils_pkg::KIND_FIND:
                if (w.element == 0)
                    a.status = ils_pkg::ST_ZERO;
                else
                begin
                    for (i = 0; i < lst.count; i++)
                    begin
                        if (!a.found && lst.cells[i] == w.element)
                        begin
                            a.found = 1'b1;
                            a.found_position = i[5:0];
                        end
                    end
                end
            default:
                lst.count = 0;
        endcase
        a.length = lst.count[6:0];
        a.empty_res = (lst.count == 0);
        return a;
    endfunction

    task automatic queue_request(ils_pkg::kind_t k, int unsigned p, logic [31:0] e);
        request_t w;
        w.kind = k;
        w.position = p[6:0];
        w.element = e;
        pending_requests.push_back(w);
        void'(apply_request(planned_list, w));
    endtask

    function automatic logic [31:0] pick_element();
        int roll;
        roll = $urandom_range(99);
        if (roll < 4)
            return 32'd0;
        if (roll < 40)
            return $urandom_range(15, 1);
        if (roll < 50)
        begin
            case ($urandom_range(3))
                0: return 32'hFFFF_FFFF;
                1: return 32'h8000_0000;
                2: return 32'h0000_0001;
                default: return 32'hAAAA_5555;
            endcase
        end
        return $urandom();
    endfunction

    // mostly legal indices with the ends favoured, some past the end
    function automatic int unsigned pick_position(ils_pkg::kind_t k, int unsigned c);
        int unsigned span;
        int unsigned lo;
        int roll;
        if (k == ils_pkg::KIND_APPEND || k == ils_pkg::KIND_FIND || k == ils_pkg::KIND_CLEAR)
            return $urandom_range(64, 0);
        span = (k == ils_pkg::KIND_SET || k == ils_pkg::KIND_INSERT) ? c + 1 : c;
        roll = $urandom_range(99);
        if (span == 0 || roll < 10)
        begin
            lo = (span > 64) ? 64 : span;
            return $urandom_range(64, lo);
        end
        if (roll < 18)
            return 0;
        if (roll < 25)
            return span - 1;
        return $urandom_range(span - 1, 0);
    endfunction

    function automatic ils_pkg::kind_t pick_kind(bit grow);
        int roll;
        roll = $urandom_range(99);
        if (grow)
        begin
            if (roll < 24) return ils_pkg::KIND_APPEND;
            if (roll < 46) return ils_pkg::KIND_INSERT;
            if (roll < 60) return ils_pkg::KIND_SET;
            if (roll < 70) return ils_pkg::KIND_GET;
            if (roll < 84) return ils_pkg::KIND_FIND;
            if (roll < 92) return ils_pkg::KIND_REMOVE;
            return ils_pkg::KIND_POP;
        end
        if (roll < 25) return ils_pkg::KIND_REMOVE;
        if (roll < 50) return ils_pkg::KIND_POP;
        if (roll < 60) return ils_pkg::KIND_GET;
        if (roll < 74) return ils_pkg::KIND_FIND;
        if (roll < 82) return ils_pkg::KIND_SET;
        if (roll < 88) return ils_pkg::KIND_INSERT;
        if (roll < 96) return ils_pkg::KIND_APPEND;
        return ils_pkg::KIND_CLEAR;
    endfunction

    // list traffic that swings between filling the store and draining it
    task automatic queue_random(int n);
        ils_pkg::kind_t k;
        int unsigned    p;
        logic [31:0]    e;
        for (int j = 0; j < n; j++)
        begin
            if (growing && planned_list.count == CAPACITY && $urandom_range(7) == 0)
                growing = 1'b0;
            else if (!growing && (planned_list.count == 0 ||
                     (planned_list.count < 8 && $urandom_range(15) == 0)))
                growing = 1'b1;
            if ($urandom_range(99) < 8)
            begin
                // noise
                k = ils_pkg::kind_t'($urandom_range(7));
                p = $urandom_range(64);
                e = $urandom();
            end
            else
            begin
                k = pick_kind(growing);
                p = pick_position(k, planned_list.count);
                e = pick_element();
                if (k == ils_pkg::KIND_FIND && planned_list.count != 0 &&
                    $urandom_range(99) < 60)
                    e = planned_list.cells[$urandom_range(planned_list.count - 1, 0)];
            end
            queue_request(k, p, e);
        end
    endtask

    task automatic drain();
        while (pending_requests.size() != 0 || req_ch.valid || awaited_answers.size() != 0)
            @(negedge clk);
    endtask

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        if (errors < 40)
            $display("tb: %s mismatch at %0t, got %0h, want %0h", field, $realtime, got, want);
        errors++;
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (rst_n && (!req_ch.valid || req_ch.ready))
        begin
            if (pending_requests.size() != 0 && (steady || $urandom_range(99) >= 6))
            begin
                next_request = pending_requests.pop_front();
                req_ch.valid    <= 1'b1;
                req_ch.kind     <= next_request.kind;
                req_ch.position <= next_request.position;
                req_ch.element  <= next_request.element;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // answer checker; predicts from every accepted request word
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (awaited_answers.size() == 0)
                    report_mismatch("unexpected word", rsp_ch.status, 0);
                else
                begin
                    oldest = awaited_answers.pop_front();
                    if (rsp_ch.status !== oldest.status)
                        report_mismatch("status", rsp_ch.status, oldest.status);
                    if (rsp_ch.read_element !== oldest.read_element)
                        report_mismatch("read_element", rsp_ch.read_element,
                                        oldest.read_element);
                    if (rsp_ch.found !== oldest.found)
                        report_mismatch("found", rsp_ch.found, oldest.found);
                    if (rsp_ch.found_position !== oldest.found_position)
                        report_mismatch("found_position", rsp_ch.found_position,
                                        oldest.found_position);
                    if (rsp_ch.length !== oldest.length)
                        report_mismatch("length", rsp_ch.length, oldest.length);
                    if (rsp_ch.empty_res !== oldest.empty_res)
                        report_mismatch("empty_res", rsp_ch.empty_res, oldest.empty_res);
                end
            end
            if (req_ch.valid && req_ch.ready)
                awaited_answers.push_back(apply_request(stored_list,
                    '{ils_pkg::kind_t'(req_ch.kind), req_ch.position, req_ch.element}));
            rsp_ch.ready <= steady || ($urandom_range(99) >= 6);
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_MAX)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.kind = ils_pkg::KIND_APPEND;
        req_ch.position = '0;
        req_ch.element = '0;
        rsp_ch.ready = 1'b0;
        steady = 1'b0;
        growing = 1'b1;
        errors = 0;
        quiet_cycles = 0;
        stored_list.count = 0;
        planned_list.count = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // empty list, zero words, error precedence, shifts, duplicates
        queue_request(ils_pkg::KIND_GET, 0, 32'd0);
        queue_request(ils_pkg::KIND_REMOVE, 0, 32'd0);
        queue_request(ils_pkg::KIND_POP, 0, 32'd3);
        queue_request(ils_pkg::KIND_FIND, 0, 32'd5);
        queue_request(ils_pkg::KIND_FIND, 0, 32'd0);
        queue_request(ils_pkg::KIND_APPEND, 0, 32'd0);
        queue_request(ils_pkg::KIND_APPEND, 64, 32'hFFFF_FFFF);
        queue_request(ils_pkg::KIND_APPEND, 0, 32'd1);
        queue_request(ils_pkg::KIND_SET, 2, 32'h8000_0000);
        queue_request(ils_pkg::KIND_SET, 4, 32'd5);
        queue_request(ils_pkg::KIND_INSERT, 9, 32'd0);
        queue_request(ils_pkg::KIND_INSERT, 0, 32'd0);
        queue_request(ils_pkg::KIND_INSERT, 3, 32'd7);
        queue_request(ils_pkg::KIND_INSERT, 1, 32'd5);
        queue_request(ils_pkg::KIND_SET, 0, 32'd1);
        queue_request(ils_pkg::KIND_FIND, 0, 32'd1);
        queue_request(ils_pkg::KIND_FIND, 0, 32'd7);
        queue_request(ils_pkg::KIND_FIND, 0, 32'd2);
        queue_request(ils_pkg::KIND_GET, 4, 32'd0);
        queue_request(ils_pkg::KIND_GET, 5, 32'd0);
        queue_request(ils_pkg::KIND_REMOVE, 1, 32'd0);
        queue_request(ils_pkg::KIND_POP, 3, 32'd0);
        queue_request(ils_pkg::KIND_POP, 0, 32'd0);
        queue_request(ils_pkg::KIND_CLEAR, 64, 32'hAAAA_5555);
        queue_request(ils_pkg::KIND_CLEAR, 0, 32'd0);
        queue_request(ils_pkg::KIND_GET, 64, 32'd0);
        drain();

        queue_random(400);
        drain();
        steady = 1'b1;
        queue_random(300);
        drain();
        steady = 1'b0;
        queue_random(450);
        drain();

        // drain has already waited for every answer, a find's answer too
        repeat (80) @(negedge clk);
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/ils_pkg.sv
sv/ils_if.sv
sv/ils_cell.sv
sv/indexed_list_store_core.sv
sim/tb.sv
